### sv/kssd_pkg.sv
// ----------------------------------------------------------------------------
// kssd_pkg - shared types and constants for the keyword score smoother
// Field widths, register indexes, reset values and the cell control word.
// ----------------------------------------------------------------------------
package kssd_pkg;

    localparam int PROB_W   = 16;
    localparam int THR_W    = 16;
    localparam int HOLD_W   = 10;
    localparam int WLEN_W   = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd32768;
    localparam logic [HOLD_W-1:0] HOLDOFF_RESET   = 10'd80;
    localparam logic [WLEN_W-1:0] WLEN_RESET      = 5'd15;

    // control word broadcast to every ring cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

### sv/keyword_score_smoother_detector.sv
// ----------------------------------------------------------------------------
// keyword_score_smoother_detector - windowed average with threshold and holdoff
// Ring of sample cells, rotated once per word to sum the window, then a serial
// divide for the average and a holdoff counter that gates detections.
// ----------------------------------------------------------------------------
// Each word is swept once round the ring into a SUM_W-bit sum, where SUM_W =
//   16 + clog2(WINDOW_MAX + 1), then divided; in_stall stays high until the
//   result is loaded, so a new word is taken only after the previous one is
//   finished, and later while a finished word waits on out_stall.
// Reset: control and config registers take reset values; ring cells clear to zero.
module keyword_score_smoother_detector
#(
    parameter int WINDOW_MAX = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [kssd_pkg::PROB_W-1:0]    keyword_prob,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           detected,
    output logic [kssd_pkg::PROB_W-1:0]    avg_score,
    output logic                           in_holdoff,
    input  logic                           cfg_we,
    input  logic [kssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kssd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = kssd_pkg::PROB_W + CNT_W;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW_MAX - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [kssd_pkg::THR_W-1:0]  thr_reg;
    logic [kssd_pkg::HOLD_W-1:0] holdoff_reg;
    logic [kssd_pkg::WLEN_W-1:0] wlen_reg;

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [kssd_pkg::PROB_W-1:0] sample_reg, sample_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [kssd_pkg::HOLD_W-1:0] hold_cnt_reg, hold_cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        detected_reg, detected_next;
    logic [kssd_pkg::PROB_W-1:0] avg_reg, avg_next;
    logic                        hold_reg, hold_next;

    logic [CNT_W-1:0]            eff_len;
    logic [CNT_W-1:0]            inc;
    logic                        wrap;
    logic                        in_accept;
    logic                        out_free;
    logic                        finish_load;
    logic                        hit;
    logic [kssd_pkg::PROB_W-1:0] head_val;
    logic [kssd_pkg::PROB_W-1:0] avg_val;
    logic                        div_start;
    logic                        div_done;
    logic [SUM_W-1:0]            div_quo;

    kssd_pkg::cell_ctrl_t        cell_ctrl;
    logic [kssd_pkg::PROB_W-1:0] cell_data [WINDOW_MAX];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= kssd_pkg::THRESHOLD_RESET;
            holdoff_reg <= kssd_pkg::HOLDOFF_RESET;
            wlen_reg    <= kssd_pkg::WLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kssd_pkg::CFG_THRESHOLD:  thr_reg     <= cfg_data[kssd_pkg::THR_W-1:0];
                kssd_pkg::CFG_HOLDOFF:    holdoff_reg <= cfg_data[kssd_pkg::HOLD_W-1:0];
                kssd_pkg::CFG_WINDOW_LEN: wlen_reg    <= cfg_data[kssd_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, long windows saturate
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (32'(wlen_reg) > WINDOW_MAX)
        begin
            eff_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = CNT_W'(wlen_reg);
        end
    end

    assign inc       = CNT_W'(idx_reg) + CNT_W'(1);
    assign wrap      = inc >= eff_len;
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_load = (state_reg == ST_FINISH) && out_free;
    assign avg_val   = div_quo[kssd_pkg::PROB_W-1:0];
    assign hit       = (hold_cnt_reg == '0) && (avg_val > thr_reg);

    // cell 0 shows ring entry pos_reg; the new sample replaces it in passing
    assign head_val  = (pos_reg == widx_reg) ? sample_reg : cell_data[0];
    assign div_start = (state_reg == ST_SWEEP) && (pos_reg == LAST_POS);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        sample_next    = sample_reg;
        widx_next      = widx_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        hold_cnt_next  = hold_cnt_reg;
        out_valid_next = out_valid_reg;
        detected_next  = detected_reg;
        avg_next       = avg_reg;
        hold_next      = hold_reg;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.clear = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sample_next = keyword_prob;
                    widx_next   = idx_reg;
                    idx_next    = wrap ? '0 : IDX_W'(inc);
                    full_next   = full_reg || wrap;
                    count_next  = (full_reg || wrap) ? eff_len : inc;
                    pos_next    = '0;
                    acc_next    = '0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cell_ctrl.shift = 1'b1;
                if (CNT_W'(pos_reg) < count_reg)
                begin
                    acc_next = acc_reg + SUM_W'(head_val);
                end
                pos_next = pos_reg + IDX_W'(1);
                if (pos_reg == LAST_POS)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = avg_val;
                    detected_next  = hit;
                    hold_next      = hold_cnt_reg != '0;
                    if (hold_cnt_reg != '0)
                    begin
                        hold_cnt_next = hold_cnt_reg - kssd_pkg::HOLD_W'(1);
                    end
                    else if (hit)
                    begin
                        hold_cnt_next   = holdoff_reg;
                        cell_ctrl.clear = 1'b1;
                        idx_next        = '0;
                        full_next       = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            hold_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            full_reg      <= full_next;
            hold_cnt_reg  <= hold_cnt_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sample_reg   <= sample_next;
        widx_reg     <= widx_next;
        count_reg    <= count_next;
        detected_reg <= detected_next;
        avg_reg      <= avg_next;
        hold_reg     <= hold_next;
    end

    // ring: each cell takes its upper neighbor, the top cell takes the head word
    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        logic [kssd_pkg::PROB_W-1:0] cell_in;
        if (g == WINDOW_MAX - 1)
        begin : g_top
            assign cell_in = head_val;
        end
        else
        begin : g_mid
            assign cell_in = cell_data[g+1];
        end
        kssd_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .din   (cell_in),
            .dout  (cell_data[g])
        );
    end

    kssd_divider
    #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_stall   = state_reg != ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign detected   = detected_reg;
    assign avg_score  = avg_reg;
    assign in_holdoff = hold_reg;

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide phase");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> count_reg != '0)
        else $error("averaging over an empty window");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        finish_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished word not posted to output");

    a_hit_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        finish_load && hit |=> hold_cnt_reg == $past(holdoff_reg) && !full_reg
            && idx_reg == '0)
        else $error("detection did not load holdoff and reset the ring");

    a_no_hit_in_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(detected_reg && hold_reg))
        else $error("detection flagged during holdoff");

endmodule

### sv/kssd_cell.sv
// ----------------------------------------------------------------------------
// kssd_cell - one ring entry
// Holds one sample; rotates toward its neighbor on shift, zeroes on clear.
// ----------------------------------------------------------------------------
module kssd_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  kssd_pkg::cell_ctrl_t      ctrl,
    input  logic [kssd_pkg::PROB_W-1:0] din,
    output logic [kssd_pkg::PROB_W-1:0] dout
);

    logic [kssd_pkg::PROB_W-1:0] sample_reg;
    logic [kssd_pkg::PROB_W-1:0] sample_next;

    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.clear)
        begin
            sample_next = '0;
        end
        else if (ctrl.shift)
        begin
            sample_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign dout = sample_reg;

endmodule

### sv/kssd_divider.sv
// ----------------------------------------------------------------------------
// kssd_divider - restoring serial divider
// One quotient bit per cycle; done pulses the cycle after the last bit.
// ----------------------------------------------------------------------------
module kssd_divider
#(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int ITER_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = ITER_W'(DIVIDEND_W);
            dq_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            dq_next   = {dq_reg[DIVIDEND_W-2:0], ge};
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

### tb/tb_keyword_score_smoother_detector.sv
// ----------------------------------------------------------------------------
// tb_keyword_score_smoother_detector - self-checking bench for the smoother
// Drives keyword probability words through a valid/stall port and predicts
// each result (window average, detection, holdoff) with a behavioral copy of
// the ring, counters and registers. Runs directed corner frames, then random
// bursts under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_keyword_score_smoother_detector;

    localparam int WIN_DEPTH = 16;
    localparam int PRESS_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [kssd_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;  // unused index, ignored

    typedef struct packed {
        logic                        detected;
        logic [kssd_pkg::PROB_W-1:0] avg;
        logic                        in_hold;
    } frame_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [kssd_pkg::PROB_W-1:0]    keyword_prob = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           detected;
    logic [kssd_pkg::PROB_W-1:0]    avg_score;
    logic                           in_holdoff;
    logic                           cfg_we = 1'b0;
    logic [kssd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kssd_pkg::CFG_W-1:0]     cfg_data = '0;

    // predictor state and register copy
    logic [kssd_pkg::PROB_W-1:0] ring [WIN_DEPTH];
    int unsigned                 wr_idx = 0;
    bit                          ring_full = 1'b0;
    logic [kssd_pkg::HOLD_W-1:0] hold_cnt = '0;
    logic [kssd_pkg::THR_W-1:0]  thr_q = kssd_pkg::THRESHOLD_RESET;
    logic [kssd_pkg::HOLD_W-1:0] hold_frames_q = kssd_pkg::HOLDOFF_RESET;
    logic [kssd_pkg::WLEN_W-1:0] wlen_q = kssd_pkg::WLEN_RESET;

    logic [kssd_pkg::PROB_W-1:0] frame_q [$];
    frame_result_t     result_q [$];
    int                mismatches = 0;
    int                snd_pct = 0;
    int                rcv_pct = 0;
    logic              press_req = 1'b0;
    int                press_left = 0;

    keyword_score_smoother_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .keyword_prob (keyword_prob),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .detected     (detected),
        .avg_score    (avg_score),
        .in_holdoff   (in_holdoff),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one frame through the window average, threshold and holdoff
    function automatic frame_result_t smooth_frame(input logic [kssd_pkg::PROB_W-1:0] prob);
        frame_result_t r;
        int unsigned   len;
        int unsigned   cnt;
        int unsigned   sum;
        len = (wlen_q == 0) ? 1 : ((wlen_q > WIN_DEPTH) ? WIN_DEPTH : wlen_q);
        if (wr_idx < WIN_DEPTH)
            ring[wr_idx] = prob;
        wr_idx++;
        // a shrunk window leaves the index past the end: wrap and count as full
        if (wr_idx >= len)
        begin
            wr_idx = 0;
            ring_full = 1'b1;
        end
        cnt = ring_full ? len : wr_idx;
        sum = 0;
        for (int i = 0; i < cnt; i++)
            sum += ring[i];
        r.detected = 1'b0;
        r.in_hold = 1'b0;
        r.avg = (cnt != 0) ? kssd_pkg::PROB_W'(sum / cnt) : '0;
        if (hold_cnt != 0)
        begin
            hold_cnt--;
            r.in_hold = 1'b1;
        end
        else if (r.avg > thr_q)
        begin
            r.detected = 1'b1;
            hold_cnt = hold_frames_q;
            foreach (ring[i])
                ring[i] = '0;
            wr_idx = 0;
            ring_full = 1'b0;
        end
        return r;
    endfunction

    // sender: record each accepted word, then offer the next one
    always @(posedge clk)
    begin
        bit taken;
        if (rst_n)
        begin
            taken = in_valid && !in_stall;
            if (taken)
                result_q.push_back(smooth_frame(keyword_prob));
            if (!in_valid || taken)
            begin
                if (frame_q.size() != 0 && $urandom_range(99) >= snd_pct)
                begin
                    in_valid <= 1'b1;
                    keyword_prob <= frame_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (press_req)
            press_left <= PRESS_CYCLES;
        else if (press_left != 0)
            press_left <= press_left - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= (press_left != 0) || ($urandom_range(99) < rcv_pct);
    end

    // receiver: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result word with no frame pending");
                mismatches++;
            end
            else
            begin
                want = result_q.pop_front();
                if (detected !== want.detected)
                begin
                    $error("detected: expected %0d, got %0d", want.detected, detected);
                    mismatches++;
                end
                if (avg_score !== want.avg)
                begin
                    $error("avg_score: expected %0d, got %0d", want.avg, avg_score);
                    mismatches++;
                end
                if (in_holdoff !== want.in_hold)
                begin
                    $error("in_holdoff: expected %0d, got %0d", want.in_hold, in_holdoff);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [kssd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kssd_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            kssd_pkg::CFG_THRESHOLD:  thr_q = data[kssd_pkg::THR_W-1:0];
            kssd_pkg::CFG_HOLDOFF:    hold_frames_q = data[kssd_pkg::HOLD_W-1:0];
            kssd_pkg::CFG_WINDOW_LEN: wlen_q = data[kssd_pkg::WLEN_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (frame_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin snd_pct = 46; rcv_pct = 0;  end
            2: begin snd_pct = 0;  rcv_pct = 46; end
            3: begin snd_pct = 14; rcv_pct = 14; end
            default: begin snd_pct = 0; rcv_pct = 0; end
        endcase
    endtask

    // bursts of quiet frames, keyword-like peaks, full-range noise and rails
    task automatic queue_bursts(input int n_frames);
        int kind;
        int len;
        int k;
        k = 0;
        while (k < n_frames)
        begin
            kind = $urandom_range(9);
            len = $urandom_range(1, 20);
            for (int j = 0; j < len && k < n_frames; j++)
            begin
                if (kind < 4)
                    frame_q.push_back(kssd_pkg::PROB_W'($urandom_range(20000)));
                else if (kind < 7)
                    frame_q.push_back(kssd_pkg::PROB_W'($urandom_range(40000, 65535)));
                else if (kind < 9)
                    frame_q.push_back(kssd_pkg::PROB_W'($urandom));
                else
                    frame_q.push_back($urandom_range(1) ? 16'hFFFF : 16'h0000);
                k++;
            end
        end
    endtask

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        foreach (ring[i])
            ring[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, no hit yet; equal rails and alternating bits
        frame_q = '{16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001};
        wait_idle();

        // window length zero acts as one frame; average equal to threshold
        write_reg(kssd_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_reg(kssd_pkg::CFG_HOLDOFF, 16'hFC00);     // masks to zero holdoff
        write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'h0000);
        frame_q = '{16'hFFFF, 16'h0000};
        wait_idle();

        // zero threshold, oversize window, short holdoff, re-trigger after it
        write_reg(kssd_pkg::CFG_THRESHOLD, 16'h0000);
        write_reg(kssd_pkg::CFG_HOLDOFF, 16'd2);
        write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'd31);
        frame_q = '{16'h1234, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001, 16'h0003};
        wait_idle();

        // partial fill, then shrink the window below the write index
        write_reg(kssd_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'd16);
        write_reg(CFG_NONE, 16'h0001);
        for (int i = 0; i < 8; i++)
            frame_q.push_back(kssd_pkg::PROB_W'($urandom));
        wait_idle();
        write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'd4);
        frame_q = '{16'h7FFF, 16'hFFFF};
        wait_idle();

        // back to reset values before the random part
        write_reg(kssd_pkg::CFG_THRESHOLD, kssd_pkg::THRESHOLD_RESET);
        write_reg(kssd_pkg::CFG_HOLDOFF, kssd_pkg::CFG_W'(kssd_pkg::HOLDOFF_RESET));
        write_reg(kssd_pkg::CFG_WINDOW_LEN, kssd_pkg::CFG_W'(kssd_pkg::WLEN_RESET));
        frame_q = '{16'hFFFF, 16'hFFFF};
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 1)
            begin
                write_reg(kssd_pkg::CFG_THRESHOLD, 16'h0000);
                write_reg(kssd_pkg::CFG_HOLDOFF, 16'h0000);
                write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'd1);
            end
            else if (ph == 7)
            begin
                write_reg(kssd_pkg::CFG_THRESHOLD, 16'd30000);
                write_reg(kssd_pkg::CFG_HOLDOFF, 16'hFFFF);   // full 1023-frame holdoff
                write_reg(kssd_pkg::CFG_WINDOW_LEN, 16'hFFFF);
            end
            else if (ph != 0)
            begin
                write_reg(kssd_pkg::CFG_THRESHOLD,
                          kssd_pkg::CFG_W'($urandom_range(15000, 50000)));
                // junk above the field width must be dropped
                write_reg(kssd_pkg::CFG_HOLDOFF,
                          kssd_pkg::CFG_W'(($urandom_range(63) << kssd_pkg::HOLD_W)
                                           | $urandom_range(12)));
                write_reg(kssd_pkg::CFG_WINDOW_LEN,
                          kssd_pkg::CFG_W'(($urandom_range(2047) << kssd_pkg::WLEN_W)
                                           | $urandom_range(31)));
                write_reg(CFG_NONE, kssd_pkg::CFG_W'($urandom));
            end
            set_idling(ph % 4);
            queue_bursts(140);
            if (ph == 4)
            begin
                @(posedge clk);
                press_req <= 1'b1;
                @(posedge clk);
                press_req <= 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
